// ===== rtl/deq_pkg.sv =====
`default_nettype none

package deq_pkg;

  // Number of words the queue can hold
  localparam int unsigned DEPTH = 8;
  // Width of the internal occupancy counter (must hold DEPTH itself)
  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned WordW = 32;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_REAR  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_REAR   = 2'd3
  } deq_op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } deq_status_e;

  typedef struct packed {
    logic [1:0]              operation;
    logic signed [WordW-1:0] value;
  } deq_req_t;

  typedef struct packed {
    logic signed [WordW-1:0] popped_value;
    logic [1:0]              status;
    logic [3:0]              occupancy;
  } deq_rsp_t;

  // Qualified commands broadcast to every cell; at most one is set
  typedef struct packed {
    logic push_front;
    logic push_rear;
    logic pop_front;
    logic pop_rear;
  } deq_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/double_ended_queue.sv =====
`default_nettype none

// Double-ended queue of signed 32-bit words, DEPTH entries deep.
// Request channel: drive req_i (operation and value) with start_i high;
// the request transfers at the rising edge where start_i is high and
// busy_o is low. busy_o stays low, so one request can transfer per cycle.
// Response channel: exactly one response per request, on rsp_o with
// done_o high for one cycle, in the cycle right after the request
// transferred (throughput 1 request per cycle). The receiver cannot
// stall; the response must be taken in that cycle.
// Storage is a row of identical cells: cell 0 holds the front word and
// occupied cells stay contiguous. Push front and pop front shift the whole
// row by one cell; push rear fills the first free cell, pop rear clears
// the last used one. Each operation is one cell update across the row,
// which sets the one-cycle rate.
// A push onto a full queue or a pop from an empty one changes nothing and
// reports full or empty status. Reset empties the queue and drops any
// pending response.
module double_ended_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire deq_pkg::deq_req_t req_i,
  output logic                   done_o,
  output deq_pkg::deq_rsp_t      rsp_o
);
  import deq_pkg::*;

  logic                    valid [DEPTH];
  logic signed [WordW-1:0] data  [DEPTH];
  logic signed [WordW-1:0] tail_word;
  logic                    accept;
  logic                    is_full, is_empty;
  deq_cmd_t                cmd;
  logic [CntW-1:0]         count_q, count_d;
  deq_rsp_t                rsp_q, rsp_d;
  logic                    done_q;

  assign busy_o   = 1'b0;
  assign accept   = start_i & ~busy_o;
  assign is_full  = valid[DEPTH-1];
  assign is_empty = ~valid[0];

  // Pick the word in the last used cell for pop rear
  always_comb begin
    tail_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (i == DEPTH - 1) begin
        if (valid[i]) tail_word = tail_word | data[i];
      end else begin
        if (valid[i] && !valid[i+1]) tail_word = tail_word | data[i];
      end
    end
  end

  // Decode the request and build the response
  always_comb begin
    cmd              = '0;
    count_d          = count_q;
    rsp_d.popped_value = '0;
    rsp_d.status     = ST_OK;
    unique case (deq_op_e'(req_i.operation))
      OP_PUSH_FRONT, OP_PUSH_REAR: begin
        if (is_full) begin
          rsp_d.status = ST_FULL;
        end else begin
          cmd.push_front = (req_i.operation == OP_PUSH_FRONT) && accept;
          cmd.push_rear  = (req_i.operation == OP_PUSH_REAR) && accept;
          count_d        = count_q + CntW'(1);
        end
      end
      OP_POP_FRONT: begin
        if (is_empty) begin
          rsp_d.status = ST_EMPTY;
        end else begin
          cmd.pop_front      = accept;
          rsp_d.popped_value = data[0];
          count_d            = count_q - CntW'(1);
        end
      end
      OP_POP_REAR: begin
        if (is_empty) begin
          rsp_d.status = ST_EMPTY;
        end else begin
          cmd.pop_rear       = accept;
          rsp_d.popped_value = tail_word;
          count_d            = count_q - CntW'(1);
        end
      end
      default: begin
        rsp_d.status = ST_OK;
      end
    endcase
    rsp_d.occupancy = 4'(count_d);
  end

  // Row of storage cells
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [WordW-1:0] left_data, right_data;
    logic                    left_valid, right_valid;

    if (g == 0) begin : g_first
      assign left_data  = req_i.value;
      assign left_valid = 1'b1;
    end else begin : g_mid_l
      assign left_data  = data[g-1];
      assign left_valid = valid[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_data  = '0;
      assign right_valid = 1'b0;
    end else begin : g_mid_r
      assign right_data  = data[g+1];
      assign right_valid = valid[g+1];
    end

    deq_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cmd_i         (cmd),
      .value_i       (req_i.value),
      .left_data_i   (left_data),
      .left_valid_i  (left_valid),
      .right_data_i  (right_data),
      .right_valid_i (right_valid),
      .data_o        (data[g]),
      .valid_o       (valid[g])
    );
  end

  // Hold the count and the response strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= accept;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  // Register the response payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

`default_nettype wire

// ===== rtl/deq_cell.sv =====
`default_nettype none

module deq_cell (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire deq_pkg::deq_cmd_t            cmd_i,
  input  wire logic signed [deq_pkg::WordW-1:0] value_i,
  input  wire logic signed [deq_pkg::WordW-1:0] left_data_i,
  input  wire logic                         left_valid_i,
  input  wire logic signed [deq_pkg::WordW-1:0] right_data_i,
  input  wire logic                         right_valid_i,
  output logic signed [deq_pkg::WordW-1:0]  data_o,
  output logic                              valid_o
);
  import deq_pkg::*;

  logic                    valid_q, valid_d;
  logic signed [WordW-1:0] data_q, data_d;
  logic                    data_en;
  logic                    first_free;
  logic                    last_used;

  // Locate the rear boundary from the neighbor's occupancy
  assign first_free = left_valid_i & ~valid_q;
  assign last_used  = valid_q & ~right_valid_i;

  // Shift rearward on push front, frontward on pop front; fill on push rear, clear on pop rear
  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    data_en = 1'b0;
    if (cmd_i.push_front) begin
      valid_d = left_valid_i;
      data_d  = left_data_i;
      data_en = 1'b1;
    end else if (cmd_i.push_rear && first_free) begin
      valid_d = 1'b1;
      data_d  = value_i;
      data_en = 1'b1;
    end else if (cmd_i.pop_front) begin
      valid_d = right_valid_i;
      data_d  = right_data_i;
      data_en = 1'b1;
    end else if (cmd_i.pop_rear && last_used) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (data_en) begin
      data_q <= data_d;
    end
  end

  assign data_o  = data_q;
  assign valid_o = valid_q;

endmodule

`default_nettype wire

// ===== rtl/deq_checker.sv =====
`default_nettype none

module deq_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              start_i,
  input wire logic              busy_o,
  input wire deq_pkg::deq_req_t req_i,
  input wire logic              done_o,
  input wire deq_pkg::deq_rsp_t rsp_o
);
  import deq_pkg::*;

  // Every transfer gives a response in the next cycle
  a_resp_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> done_o)
    else $error("missing response after transfer");

  // No response without a transfer
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start_i && !busy_o) |=> !done_o)
    else $error("response without transfer");

  // Full status reports a full queue
  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status == ST_FULL) |-> (rsp_o.occupancy == 4'(DEPTH)
      && rsp_o.popped_value == '0))
    else $error("full status with wrong occupancy");

  // Empty status reports an empty queue and no word
  a_empty_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status == ST_EMPTY) |-> (rsp_o.occupancy == 4'd0
      && rsp_o.popped_value == '0))
    else $error("empty status with data or occupancy");

endmodule

bind double_ended_queue deq_checker u_deq_checker (.*);

`default_nettype wire
